@@ hdl/mkpt_pkg.sv @@
// Shared types and constants of the Morse key period timer.
`timescale 1ns / 1ps
package mkpt_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        right_level;
    logic        left_level;
    logic [1:0]  mode;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] twitches;
    logic [1:0]  transmitter;
    logic        last;
  } out_t;

  // Result event codes.
  localparam logic [2:0] EV_RIGHT         = 3'd0;
  localparam logic [2:0] EV_LEFT          = 3'd1;
  localparam logic [2:0] EV_DOWN_AFTER_UP = 3'd2;
  localparam logic [2:0] EV_UP_AFTER_DOWN = 3'd3;
  localparam logic [2:0] EV_PARTIAL_DOWN  = 3'd4;
  localparam logic [2:0] EV_PARTIAL_UP    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_TWITCH_LEN = 2'd0;
  localparam logic [1:0] REG_TX_NUM     = 2'd1;

  // Mode codes.
  localparam logic [1:0] MODE_KEYING_STD  = 2'd0;
  localparam logic [1:0] MODE_KEYING_SWAP = 2'd1;

  localparam logic [15:0] PARTIAL_LIMIT   = 16'd100;
  localparam logic [15:0] TWITCH_LEN_RST  = 16'd10;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

endpackage

@@ hdl/mkpt_divider.sv @@
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module mkpt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [15:0] remainder_o
);
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic        fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = dividend_i;
      rem_d  = 16'd0;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], fits};
      rem_d = fits ? diff[15:0] : shifted[15:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ hdl/morse_key_period_timer.sv @@
// Flow: an accepted item passes through S_ACC and S_CHK to S_EVAL, with S_DIV between
// S_CHK and S_EVAL when its remainder needs the 32-step bit-serial divider. S_EMIT
// then issues its results one at a time from a registered output, as the output is free.
// Throughput: a new item is taken only in S_IDLE, after all results of the last one
// are issued, so any output stall also holds the input.
// Reset (asynchronous, active low) clears the timing state, the contact and key flags,
// the sequencer and the output valid, and loads the configuration reset values.
`timescale 1ns / 1ps
module morse_key_period_timer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mkpt_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mkpt_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  import mkpt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_EVAL = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e      state_q, state_d;

  logic [15:0] len_cfg_q;
  logic [1:0]  tx_q;
  logic [15:0] len_eff;

  logic [31:0] prev_q, prev_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] total_q, total_d;
  logic        key_q, key_d;
  logic        right_q, right_d;
  logic        left_q, left_d;
  logic        rc_q, lc_q;
  logic [1:0]  mode_q;

  logic [2:0]  res_ev_q [3];
  logic [15:0] res_tw_q [3];
  logic [2:0]  res_ev_d [3];
  logic [15:0] res_tw_d [3];
  logic [1:0]  res_n_q, res_n_d;
  logic [1:0]  idx_q, idx_d;

  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic        in_fire;
  logic        out_free;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [15:0] div_rem;
  logic [16:0] rem_plus;
  logic [16:0] sat_sum;
  logic [15:0] total_sat;

  assign len_eff     = (len_cfg_q == 16'd0) ? 16'd1 : len_cfg_q;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign div_start = (state_q == S_CHK) && (rem_q > {16'd0, len_eff});

  mkpt_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rem_q - 32'd1),
    .divisor_i   (len_eff),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // New remainder is ((rem - 1) mod len) + 1, so it ends in 1..len.
  assign rem_plus  = {1'b0, div_rem} + 17'd1;
  assign sat_sum   = {1'b0, total_q} + {1'b0, div_quo[15:0]};
  assign total_sat = ((div_quo[31:16] != 16'd0) || sat_sum[16]) ? COUNT_MAX : sat_sum[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= TWITCH_LEN_RST;
      tx_q      <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TWITCH_LEN: len_cfg_q <= cfg_data_i;
        REG_TX_NUM:     tx_q      <= cfg_data_i[1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    logic [1:0]  n;
    logic [15:0] tot;
    logic        down;
    logic        kd;
    state_d     = state_q;
    prev_d      = prev_q;
    delta_d     = delta_q;
    rem_d       = rem_q;
    total_d     = total_q;
    key_d       = key_q;
    right_d     = right_q;
    left_d      = left_q;
    res_ev_d    = res_ev_q;
    res_tw_d    = res_tw_q;
    res_n_d     = res_n_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    n           = 2'd0;
    tot         = total_q;
    down        = rc_q || lc_q;
    kd          = key_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          delta_d = in_data_i.now_ms - prev_q;
          prev_d  = in_data_i.now_ms;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        rem_d   = rem_q + delta_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = div_start ? S_DIV : S_EVAL;
      end
      S_DIV: begin
        if (div_done) begin
          rem_d   = {15'd0, rem_plus};
          total_d = total_sat;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // Results are packed in order: right closure, left closure, then a key
        // transition or a partial report.
        if (!right_q && rc_q) begin
          res_ev_d[n] = EV_RIGHT;
          res_tw_d[n] = 16'd0;
          n = n + 2'd1;
        end
        if (!left_q && lc_q) begin
          res_ev_d[n] = EV_LEFT;
          res_tw_d[n] = 16'd0;
          n = n + 2'd1;
        end
        right_d = rc_q;
        left_d  = lc_q;
        if ((mode_q == MODE_KEYING_STD || mode_q == MODE_KEYING_SWAP)
            && (down != key_q)) begin
          res_ev_d[n] = down ? EV_DOWN_AFTER_UP : EV_UP_AFTER_DOWN;
          res_tw_d[n] = total_q;
          n     = n + 2'd1;
          kd    = down;
          tot   = 16'd0;
          rem_d = 32'd0;
        end
        if (tot >= PARTIAL_LIMIT) begin
          res_ev_d[n] = kd ? EV_PARTIAL_DOWN : EV_PARTIAL_UP;
          res_tw_d[n] = tot;
          n   = n + 2'd1;
          tot = 16'd0;
        end
        key_d   = kd;
        total_d = tot;
        res_n_d = n;
        idx_d   = 2'd0;
        state_d = (n == 2'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.event_res   = res_ev_q[idx_q];
          out_d.twitches    = res_tw_q[idx_q];
          out_d.transmitter = tx_q;
          out_d.last        = (idx_q == res_n_q - 2'd1);
          idx_d             = idx_q + 2'd1;
          if (idx_q == res_n_q - 2'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= 32'd0;
      rem_q       <= 32'd0;
      total_q     <= 16'd0;
      key_q       <= 1'b0;
      right_q     <= 1'b0;
      left_q      <= 1'b0;
      res_n_q     <= 2'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      rem_q       <= rem_d;
      total_q     <= total_d;
      key_q       <= key_d;
      right_q     <= right_d;
      left_q      <= left_d;
      res_n_q     <= res_n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    res_ev_q <= res_ev_d;
    res_tw_q <= res_tw_d;
    out_q    <= out_d;
    if (in_fire) begin
      rc_q   <= !in_data_i.right_level;
      lc_q   <= !in_data_i.left_level;
      mode_q <= in_data_i.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/mkpt_checker.sv @@
// Port-level checker for the Morse key period timer and its bind statement.
`timescale 1ns / 1ps
module mkpt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mkpt_pkg::out_t out_data_o
);
  import mkpt_pkg::*;

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  // Contact closure events never carry a period length.
  a_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_res == EV_RIGHT || out_data_o.event_res == EV_LEFT))
    |-> (out_data_o.twitches == 16'd0))
    else $error("contact event with nonzero twitch count");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.event_res <= EV_PARTIAL_UP))
    else $error("undefined event code");

endmodule

bind morse_key_period_timer mkpt_checker u_mkpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
